>>> src/sd_spi_transaction_engine_defines.svh
// Assertion macros for the SD SPI transaction engine modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SD_SPI_TRANSACTION_ENGINE_DEFINES_SVH
`define SD_SPI_TRANSACTION_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SDS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SDS_ASSERT(label, clk, rst, prop, msg)
`define SDS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> src/sds_pkg.sv
// Shared types and constants for the SD SPI transaction engine.
// No dependencies.
package sds_pkg;
   localparam int MAX_BLOCK_BYTES = 4096;
   localparam int INIT_DUMMY_BYTES = 10;
   localparam int FIFO_DEPTH = 2;

   typedef enum logic [4:0] {
      PH_IDLE, PH_INIT_DUMMY, PH_FRAME, PH_POLL_R1, PH_OPCOND_GAP, PH_OPCOND_FRAME,
      PH_POLL_OPCOND, PH_POLL_TOKEN, PH_DATA_IN, PH_CRC_IN, PH_WR_GAP, PH_WR_TOKEN,
      PH_WR_DATA, PH_WR_CRC, PH_DRESP, PH_BUSY, PH_STATUS_READ, PH_CLOSE
   } phase_type;

   localparam logic [1:0] CSR_BLOCK_BYTES = 2'd0;
   localparam logic [1:0] CSR_POLL_LIMIT = 2'd1;
   localparam logic [1:0] CSR_DRESP_TRIES = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_TIMEOUT = 3'd1;
   localparam logic [2:0] ST_CRC = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_OTHER = 3'd4;

   typedef struct packed {
      logic        command;
      logic [2:0]  operation;
      logic [31:0] block_address;
      logic [7:0]  received_byte;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] send_byte;
      logic       send_valid;
      logic       select_low;
      logic [7:0] data_byte;
      logic       data_valid;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

   // Front-end classification of a request.
   typedef struct packed {
      logic        start;
      logic        bad_op;
      logic [2:0]  operation;
      logic [31:0] block_address;
      logic [7:0]  received_byte;
      logic [7:0]  payload_byte;
      logic [4:0]  data_resp;
   } cls_type;

   function automatic logic [5:0] op_cmd(input logic [2:0] op);
      case (op)
         3'd1: op_cmd = 6'd17;
         3'd2: op_cmd = 6'd24;
         3'd3: op_cmd = 6'd9;
         3'd4: op_cmd = 6'd10;
         3'd5: op_cmd = 6'd13;
         default: op_cmd = 6'd0;
      endcase
   endfunction
endpackage

>>> src/sd_spi_transaction_engine.sv
// SD card SPI-mode host sequencer: one request per completed byte exchange,
// one result per request, up to one request per clock cycle sustained.
// Each request passes a two-entry input queue and the combinational phase logic,
// then waits in a two-entry result queue; its result is registered into that
// queue when the sequencer takes the request. The sequencer pauses while the result
// queue is full, and req_full rises once the input queue has filled behind it.
// The user writes registers with csr_we only while idle; the block does not enforce it.
// Depends on sds_pkg, sds_front and sds_back.
module sd_spi_transaction_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sds_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sds_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   logic [12:0] blk_ff;
   logic [15:0] poll_ff;
   logic [7:0]  tries_ff;
   logic [12:0] blk_len;
   logic [15:0] poll_limit;
   logic [7:0]  dresp_limit;
   logic cls_valid, cls_take;
   sds_pkg::cls_type cls_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= 13'd512;
         poll_ff <= 16'd4095;
         tries_ff <= 8'd65;
      end else if (csr_we) begin
         case (csr_index)
            sds_pkg::CSR_BLOCK_BYTES: blk_ff <= csr_wdata[12:0];
            sds_pkg::CSR_POLL_LIMIT: poll_ff <= csr_wdata;
            sds_pkg::CSR_DRESP_TRIES: tries_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      blk_len = (blk_ff == 13'd0) ? 13'd1
         : (blk_ff > 13'(sds_pkg::MAX_BLOCK_BYTES)) ? 13'(sds_pkg::MAX_BLOCK_BYTES) : blk_ff;
      poll_limit = (poll_ff == 16'd0) ? 16'd1 : poll_ff;
      dresp_limit = (tries_ff == 8'd0) ? 8'd1 : tries_ff;
   end

   sds_front u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .req_data(req_data), .cls_valid(cls_valid), .cls_take(cls_take),
      .cls_data(cls_data)
   );

   sds_back u_back (
      .clock(clock), .reset(reset), .cls_valid(cls_valid), .cls_take(cls_take),
      .cls_data(cls_data), .blk_len(blk_len), .poll_limit(poll_limit),
      .dresp_limit(dresp_limit), .empty(rsp_empty), .pop(rsp_pop),
      .rsp_data(rsp_data)
   );
endmodule

>>> src/sds_front.sv
// Request front end: classifies each request and queues it for the sequencer.
// Depends on sds_pkg.
module sds_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sds_pkg::req_type  req_data,
   output logic              cls_valid,
   input  logic              cls_take,
   output sds_pkg::cls_type  cls_data
);
   sds_pkg::cls_type q_ff [sds_pkg::FIFO_DEPTH];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   sds_pkg::cls_type cls;
   logic do_push, do_pop;

   always_comb begin
      cls.start = ~req_data.command;
      cls.bad_op = req_data.operation > 3'd5;
      cls.operation = req_data.operation;
      cls.block_address = req_data.block_address;
      cls.received_byte = req_data.received_byte;
      cls.payload_byte = req_data.payload_byte;
      cls.data_resp = req_data.received_byte[4:0];
   end

   assign full = count_ff == 2'(sds_pkg::FIFO_DEPTH);
   assign cls_valid = count_ff != 2'd0;
   assign cls_data = q_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop = cls_take & cls_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule

>>> src/sds_back.sv
// Sequencer back end: runs the SD SPI phases, one queued request per cycle while the
// result queue has room, with a two-entry result queue. Depends on sds_pkg and the defines header.
`include "sd_spi_transaction_engine_defines.svh"
module sds_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cls_valid,
   output logic              cls_take,
   input  sds_pkg::cls_type  cls_data,
   input  logic [12:0]       blk_len,
   input  logic [15:0]       poll_limit,
   input  logic [7:0]        dresp_limit,
   output logic              empty,
   input  logic              pop,
   output sds_pkg::rsp_type  rsp_data
);
   sds_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] addr_ff, addr_in;
   logic [12:0] bc_ff, bc_in;
   logic [15:0] pc_ff, pc_in;
   logic [2:0]  fs_ff, fs_in;
   sds_pkg::rsp_type r;
   sds_pkg::rsp_type oq_ff [2];
   logic owr_ff, ord_ff;
   logic [1:0] ocnt_ff;
   logic ofull, step;
   logic [15:0] pc_inc;
   logic [12:0] bc_inc;
   logic [7:0] rx;

   assign ofull = ocnt_ff == 2'd2;
   assign cls_take = ~ofull;
   assign step = cls_valid & ~ofull;
   assign empty = ocnt_ff == 2'd0;
   assign rsp_data = oq_ff[ord_ff];
   assign pc_inc = pc_ff + 16'd1;
   assign bc_inc = bc_ff + 13'd1;
   assign rx = cls_data.received_byte;

   function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic opc,
                                            input logic [2:0] op, input logic [31:0] a);
      logic [5:0] cmd;
      logic [31:0] arg;
      cmd = opc ? 6'd1 : sds_pkg::op_cmd(op);
      arg = (!opc && (op == 3'd1 || op == 3'd2)) ? a : 32'd0;
      case (idx)
         3'd0: frame_byte = {2'b01, cmd};
         3'd1: frame_byte = arg[31:24];
         3'd2: frame_byte = arg[23:16];
         3'd3: frame_byte = arg[15:8];
         3'd4: frame_byte = arg[7:0];
         default: frame_byte = (cmd == 6'd0) ? 8'h95 : 8'hFF;
      endcase
   endfunction

   // Next-state block.
   always_comb begin
      phase_in = phase_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      bc_in = bc_ff;
      pc_in = pc_ff;
      fs_in = fs_ff;
      if (cls_data.start) begin
         op_in = cls_data.operation;
         addr_in = cls_data.block_address;
         bc_in = 13'd0;
         pc_in = 16'd0;
         fs_in = sds_pkg::ST_OK;
         if (cls_data.bad_op) phase_in = sds_pkg::PH_IDLE;
         else if (cls_data.operation == 3'd0) phase_in = sds_pkg::PH_INIT_DUMMY;
         else phase_in = sds_pkg::PH_FRAME;
      end else begin
         case (phase_ff)
            sds_pkg::PH_INIT_DUMMY: begin
               if (bc_inc < 13'(sds_pkg::INIT_DUMMY_BYTES)) bc_in = bc_inc;
               else begin
                  bc_in = 13'd0;
                  phase_in = sds_pkg::PH_FRAME;
               end
            end
            sds_pkg::PH_FRAME, sds_pkg::PH_OPCOND_FRAME: begin
               if (bc_ff < 13'd5) bc_in = bc_inc;
               else begin
                  pc_in = 16'd0;
                  bc_in = 13'd0;
                  if (phase_ff == sds_pkg::PH_OPCOND_FRAME) phase_in = sds_pkg::PH_POLL_OPCOND;
                  else if (op_ff == 3'd5) phase_in = sds_pkg::PH_STATUS_READ;
                  else phase_in = sds_pkg::PH_POLL_R1;
               end
            end
            sds_pkg::PH_POLL_R1: begin
               if (rx == ((op_ff == 3'd0) ? 8'h01 : 8'h00)) begin
                  pc_in = 16'd0;
                  if (op_ff == 3'd0) phase_in = sds_pkg::PH_OPCOND_GAP;
                  else if (op_ff == 3'd2) phase_in = sds_pkg::PH_WR_GAP;
                  else phase_in = sds_pkg::PH_POLL_TOKEN;
               end else begin
                  pc_in = pc_inc;
                  if (pc_inc >= poll_limit) begin
                     fs_in = sds_pkg::ST_TIMEOUT;
                     phase_in = sds_pkg::PH_CLOSE;
                  end
               end
            end
            sds_pkg::PH_OPCOND_GAP: begin
               bc_in = 13'd0;
               phase_in = sds_pkg::PH_OPCOND_FRAME;
            end
            sds_pkg::PH_POLL_OPCOND: begin
               if (rx == 8'h00) begin
                  fs_in = sds_pkg::ST_OK;
                  phase_in = sds_pkg::PH_CLOSE;
               end else if (pc_inc >= poll_limit) begin
                  pc_in = 16'd0;
                  phase_in = sds_pkg::PH_OPCOND_GAP;
               end else pc_in = pc_inc;
            end
            sds_pkg::PH_POLL_TOKEN: begin
               if (rx == 8'hFE) begin
                  phase_in = sds_pkg::PH_DATA_IN;
                  bc_in = 13'd0;
               end else begin
                  pc_in = pc_inc;
                  if (pc_inc >= poll_limit) begin
                     fs_in = sds_pkg::ST_TIMEOUT;
                     phase_in = sds_pkg::PH_CLOSE;
                  end
               end
            end
            sds_pkg::PH_DATA_IN: begin
               bc_in = bc_inc;
               if (bc_inc >= ((op_ff == 3'd1) ? blk_len : 13'd16)) begin
                  phase_in = sds_pkg::PH_CRC_IN;
                  bc_in = 13'd0;
               end
            end
            sds_pkg::PH_CRC_IN: begin
               bc_in = bc_inc;
               if (bc_inc >= 13'd2) begin
                  fs_in = sds_pkg::ST_OK;
                  phase_in = sds_pkg::PH_CLOSE;
               end
            end
            sds_pkg::PH_WR_GAP: phase_in = sds_pkg::PH_WR_TOKEN;
            sds_pkg::PH_WR_TOKEN: begin
               phase_in = sds_pkg::PH_WR_DATA;
               bc_in = 13'd0;
            end
            sds_pkg::PH_WR_DATA: begin
               bc_in = bc_inc;
               if (bc_inc >= blk_len) begin
                  phase_in = sds_pkg::PH_WR_CRC;
                  bc_in = 13'd0;
               end
            end
            sds_pkg::PH_WR_CRC: begin
               bc_in = bc_inc;
               if (bc_inc >= 13'd2) begin
                  phase_in = sds_pkg::PH_DRESP;
                  pc_in = 16'd0;
               end
            end
            sds_pkg::PH_DRESP: begin
               if (cls_data.data_resp == 5'h05) begin
                  fs_in = sds_pkg::ST_OK;
                  phase_in = sds_pkg::PH_BUSY;
               end else if (cls_data.data_resp == 5'h0B) begin
                  fs_in = sds_pkg::ST_CRC;
                  phase_in = sds_pkg::PH_CLOSE;
               end else if (cls_data.data_resp == 5'h0D) begin
                  fs_in = sds_pkg::ST_WRITE;
                  phase_in = sds_pkg::PH_CLOSE;
               end else begin
                  pc_in = pc_inc;
                  if (pc_inc >= {8'd0, dresp_limit}) begin
                     fs_in = sds_pkg::ST_OTHER;
                     phase_in = sds_pkg::PH_BUSY;
                  end
               end
            end
            sds_pkg::PH_BUSY: if (rx != 8'h00) phase_in = sds_pkg::PH_CLOSE;
            sds_pkg::PH_STATUS_READ: begin
               bc_in = bc_inc;
               if (bc_inc >= 13'd2) begin
                  fs_in = sds_pkg::ST_OK;
                  phase_in = sds_pkg::PH_CLOSE;
               end
            end
            default: phase_in = sds_pkg::PH_IDLE;
         endcase
      end
   end

   // Output block: the result of this request, computed from current state.
   always_comb begin
      r = '0;
      if (cls_data.start) begin
         if (cls_data.bad_op) begin
            r.done_res = 1'b1;
            r.status = sds_pkg::ST_OTHER;
         end else begin
            r.send_valid = 1'b1;
            r.select_low = cls_data.operation != 3'd0;
            r.send_byte = (cls_data.operation == 3'd0) ? 8'hFF
               : {2'b01, sds_pkg::op_cmd(cls_data.operation)};
         end
      end else begin
         case (phase_ff)
            sds_pkg::PH_IDLE: r = '0;
            sds_pkg::PH_CLOSE: begin
               r.done_res = 1'b1;
               r.status = fs_ff;
            end
            default: begin
               r.send_valid = 1'b1;
               r.send_byte = 8'hFF;
               r.select_low = phase_in != sds_pkg::PH_CLOSE
                  && phase_in != sds_pkg::PH_OPCOND_GAP;
               if (phase_ff == sds_pkg::PH_DATA_IN || phase_ff == sds_pkg::PH_STATUS_READ) begin
                  r.data_valid = 1'b1;
                  r.data_byte = rx;
               end
               if (phase_in == sds_pkg::PH_FRAME || phase_in == sds_pkg::PH_OPCOND_FRAME) begin
                  r.send_byte = frame_byte(bc_in[2:0], phase_in == sds_pkg::PH_OPCOND_FRAME,
                                           op_ff, addr_ff);
               end else if (phase_ff == sds_pkg::PH_WR_GAP) begin
                  r.send_byte = 8'hFE;
               end else if (phase_in == sds_pkg::PH_WR_DATA) begin
                  r.send_byte = cls_data.payload_byte;
               end
               if (phase_ff == sds_pkg::PH_INIT_DUMMY && phase_in == sds_pkg::PH_INIT_DUMMY) begin
                  r.select_low = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sds_pkg::PH_IDLE;
         op_ff <= 3'd0;
         addr_ff <= 32'd0;
         bc_ff <= 13'd0;
         pc_ff <= 16'd0;
         fs_ff <= 3'd0;
         owr_ff <= 1'b0;
         ord_ff <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            op_ff <= op_in;
            addr_ff <= addr_in;
            bc_ff <= bc_in;
            pc_ff <= pc_in;
            fs_ff <= fs_in;
         end
         owr_ff <= owr_ff ^ step;
         ord_ff <= ord_ff ^ (pop & ~empty);
         ocnt_ff <= ocnt_ff + {1'b0, step} - {1'b0, pop & ~empty};
      end
   end

   always_ff @(posedge clock) begin
      if (step) oq_ff[owr_ff] <= r;
   end

   `SDS_ASSERT(a_no_take_full, clock, reset, ofull |-> !cls_take, "took request with full output")
   `SDS_ASSERT(a_cnt_range, clock, reset, ocnt_ff != 2'd3, "result count overflow")
   `SDS_ASSERT(a_close_idle, clock, reset,
      (step && !cls_data.start && phase_ff == sds_pkg::PH_CLOSE) |=> phase_ff == sds_pkg::PH_IDLE,
      "close did not return to idle")
endmodule
